// ===== sv/assert_macros.svh =====
// Assertion macros shared by the files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/dds_pkg.sv =====
`default_nettype none

package dds_pkg;

    localparam int DIST_W = 16;

    typedef logic [DIST_W-1:0] dist_t;

    localparam dist_t DIST_INF = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RELAX
    } state_t;

    typedef struct packed {
        logic init;
        logic relax;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/dds_cell.sv =====
`default_nettype none

module dds_cell
    import dds_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IW = 6,
    parameter int CW = 7
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cell_ctrl_t    ctrl,
    input  wire logic [CW-1:0] init_n,
    input  wire logic [IW-1:0] init_src,
    input  wire logic [IW-1:0] last_idx,
    input  wire logic [IW-1:0] pick_node,
    input  wire dist_t         pick_dist,
    input  wire dist_t         best_in,
    input  wire logic [IW-1:0] pick_in,
    input  wire dist_t         last_in,
    output dist_t              best_out,
    output logic [IW-1:0]      pick_out,
    output dist_t              last_out
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
    localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

    dist_t           dist_reg;
    dist_t           dist_next;
    logic            visited_reg;
    logic            visited_next;
    dist_t           best_reg;
    dist_t           best_next;
    logic [IW-1:0]   pick_reg;
    logic [IW-1:0]   pick_next;
    dist_t           last_reg;
    dist_t           last_next;

    logic [IW-1:0]   diff;
    logic [IW:0]     weight;
    logic [DIST_W:0] sum;
    dist_t           cand;
    logic            take;

    always_comb
    begin
        diff   = (MY_IDX > pick_node) ? (MY_IDX - pick_node) : (pick_node - MY_IDX);
        weight = {diff, 1'b0} - (IW+1)'(1);
        sum    = {1'b0, pick_dist} + (DIST_W+1)'(weight);
        cand   = sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];

        dist_next    = dist_reg;
        visited_next = visited_reg;
        if (ctrl.init)
        begin
            dist_next    = (MY_IDX == init_src) ? '0 : DIST_INF;
            visited_next = (MY_CNT >= init_n);
        end
        else if (ctrl.relax)
        begin
            if (MY_IDX == pick_node)
            begin
                visited_next = 1'b1;
            end
            else if (!visited_reg && pick_dist != DIST_INF && cand < dist_reg)
            begin
                dist_next = cand;
            end
        end

        take      = !visited_reg && (dist_reg <= best_in);
        best_next = take ? dist_reg : best_in;
        pick_next = take ? MY_IDX : pick_in;
        last_next = (MY_IDX == last_idx) ? dist_reg : last_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= 1'b0;
        end
        else
        begin
            visited_reg <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        best_reg <= best_next;
        pick_reg <= pick_next;
        last_reg <= last_next;
    end

    assign best_out = best_reg;
    assign pick_out = pick_reg;
    assign last_out = last_reg;

endmodule

`default_nettype wire

// ===== sv/dense_dijkstra_shortest_path.sv =====
// Shortest path over a generated complete graph, one request at a time.
// A request word (node_count, source) is taken at a rising edge where start
// is high and busy is low. Each result word (last_distance, bad_request) is
// shown for exactly one cycle with done high; the receiver cannot stall it.
// A rejected request (zero node count, count above MAX_NODES or source not
// below the count) gives its result in the next cycle and busy stays low.
// A good request raises busy and runs N rounds, N being node_count. Each
// round is a scan wave that crosses the row of MAX_NODES cells, one cell a
// cycle, to find the closest unvisited node, then a relax step in which every
// cell relaxes its own distance in parallel. A last wave fetches the
// distance of node N-1. The result comes after that last wave, and busy
// falls in the same cycle as done rises, so the next request can be taken
// then; the length of the cell row sets how long each scan wave lasts.
// Reset clears the controller and the visited flags; distances are written
// by each request before they are read.
`default_nettype none
`include "assert_macros.svh"

module dense_dijkstra_shortest_path
    import dds_pkg::*;
#(
    parameter int MAX_NODES = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [6:0] node_count,
    input  wire logic [5:0] source,
    output logic            done,
    output logic [15:0]     last_distance,
    output logic            bad_request
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [IW-1:0] SCAN_LAST = IW'(MAX_NODES - 1);

    state_t          state_reg;
    state_t          state_next;
    logic [IW-1:0]   scan_cnt_reg;
    logic [IW-1:0]   scan_cnt_next;
    logic [CW-1:0]   round_reg;
    logic [CW-1:0]   round_next;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   n_next;
    logic            done_reg;
    logic            done_next;
    dist_t           last_reg;
    dist_t           last_next;
    logic            bad_reg;
    logic            bad_next;

    logic            accept;
    logic            req_ok;
    cell_ctrl_t      ctrl;
    logic [CW-1:0]   init_n;
    logic [IW-1:0]   init_src;
    logic [IW-1:0]   last_idx;

    dist_t           best_w [MAX_NODES+1];
    logic [IW-1:0]   pick_w [MAX_NODES+1];
    dist_t           last_w [MAX_NODES+1];

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign req_ok   = (node_count != 7'd0) && ({1'b0, source} < node_count)
                      && (11'(node_count) <= 11'(MAX_NODES));
    assign init_n   = CW'(node_count);
    assign init_src = IW'(source);
    assign last_idx = IW'(n_reg - CW'(1));

    assign best_w[0] = DIST_INF;
    assign pick_w[0] = '0;
    assign last_w[0] = '0;

    for (genvar i = 0; i < MAX_NODES; i++)
    begin : g_cell
        dds_cell #(
            .INDEX (i),
            .IW    (IW),
            .CW    (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .init_n    (init_n),
            .init_src  (init_src),
            .last_idx  (last_idx),
            .pick_node (pick_w[MAX_NODES]),
            .pick_dist (best_w[MAX_NODES]),
            .best_in   (best_w[i]),
            .pick_in   (pick_w[i]),
            .last_in   (last_w[i]),
            .best_out  (best_w[i+1]),
            .pick_out  (pick_w[i+1]),
            .last_out  (last_w[i+1])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        round_next    = round_reg;
        n_next        = n_reg;
        done_next     = 1'b0;
        last_next     = last_reg;
        bad_next      = bad_reg;
        ctrl          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_ok)
                    begin
                        ctrl.init     = 1'b1;
                        n_next        = init_n;
                        round_next    = '0;
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        last_next = '0;
                        bad_next  = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + IW'(1);
                if (scan_cnt_reg == SCAN_LAST)
                begin
                    state_next = ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                if (round_reg == n_reg)
                begin
                    done_next  = 1'b1;
                    last_next  = last_w[MAX_NODES];
                    bad_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.relax    = 1'b1;
                    round_next    = round_reg + CW'(1);
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            round_reg    <= '0;
            n_reg        <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            round_reg    <= round_next;
            n_reg        <= n_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    assign done          = done_reg;
    assign last_distance = last_reg;
    assign bad_request   = bad_reg;

    // A good request starts a scan; a rejected one leaves the block idle.
    `ASSERT_CLK(a_accept_scan, accept && req_ok |=> state_reg == ST_SCAN, "good request not started")
    `ASSERT_CLK(a_reject_idle, accept && !req_ok |=> state_reg == ST_IDLE && done && bad_request, "rejected request mishandled")
    // Each relaxation moves on by exactly one round.
    `ASSERT_CLK(a_round_step, state_reg == ST_RELAX && round_reg != n_reg |=> state_reg == ST_SCAN && round_reg == $past(round_reg) + CW'(1), "round count slipped")
    // The round count never passes the node count while a request is running.
    `ASSERT_CLK(a_round_bound, !busy || round_reg <= n_reg, "round count beyond node count")

endmodule

`default_nettype wire
